>>> rtl/mbr_pkg.sv
// Shared types, constants and codes of the MSB-first bit reader.
package mbr_pkg;

    // Buffer geometry
    localparam int BUF_BITS   = 64;
    localparam int FIELD_BITS = 32;
    localparam int BYTE_BITS  = 8;
    localparam int HELD_W     = $clog2(BUF_BITS + 1);
    localparam int SUM_W      = HELD_W + 1;

    // Fixed field widths
    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int VALUE_W = 32;
    localparam int AVAIL_W = 7;
    localparam int STAT_W  = 2;

    // Packed stream widths
    localparam int S_DATA_W = 48;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 40;
    localparam int M_USER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_GET  = 2'd1,
        OP_SKIP = 2'd2,
        OP_PUT  = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_UNDERRUN = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_COUNT    = 2'd3
    } status_t;

    typedef struct packed {
        op_t                opcode;
        logic [BYTE_W-1:0]  byte_value;
        logic [COUNT_W-1:0] bit_count;
        logic [VALUE_W-1:0] put_value;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] extracted;
        logic [AVAIL_W-1:0] bits_available;
        status_t            status;
    } result_t;

endpackage

>>> rtl/msb_first_bit_reader_top.sv
// Top level of the MSB-first bit reader: stream ports, stages and checks.
//
// MSB-first bit reader over a byte stream with a 64-bit buffer. Each item is
// one operation (load byte, get up to 32 bits, skip up to 64 bits, put back up
// to 32 bits) and gives exactly one result with the extracted field, the bits
// left in the buffer and a status. One item is accepted per cycle unless m_tready
// holds the result register; an item passes through the input register and then
// the result register, around one pass of barrel shifters. The buffer state
// advances when an item moves into the result register, so back-to-back items
// see each other's effect without stalls.
module msb_first_bit_reader_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // byte_value [7:0], bit_count [14:8], put_value [46:15], zero [47]
    input  logic [mbr_pkg::S_DATA_W-1:0]  s_tdata,
    // opcode [1:0]
    input  logic [mbr_pkg::S_USER_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // extracted [31:0], bits_available [38:32], zero [39]
    output logic [mbr_pkg::M_DATA_W-1:0]  m_tdata,
    // status [1:0]
    output logic [mbr_pkg::M_USER_W-1:0]  m_tuser
);

    mbr_pkg::item_t             s_item;
    mbr_pkg::item_t             item;
    mbr_pkg::result_t           result;
    mbr_pkg::result_t           m_result;
    logic                       item_valid;
    logic                       advance;
    logic [mbr_pkg::HELD_W-1:0] held;

    // Unpack the incoming item
    assign s_item.opcode     = mbr_pkg::op_t'(s_tuser[mbr_pkg::OP_W-1:0]);
    assign s_item.byte_value = s_tdata[7:0];
    assign s_item.bit_count  = s_tdata[14:8];
    assign s_item.put_value  = s_tdata[46:15];

    mbr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mbr_exec u_exec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .advance (advance),
        .result  (result),
        .held    (held)
    );

    mbr_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_result   (m_result)
    );

    // Pack the result
    assign m_tdata = {1'b0, m_result.bits_available, m_result.extracted};
    assign m_tuser = m_result.status;

    // Buffer fill never exceeds its capacity
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held <= mbr_pkg::HELD_W'(mbr_pkg::BUF_BITS))
        else $error("bit buffer fill above capacity");

    // State moves only when an item executes
    a_held_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(held))
        else $error("bit buffer fill changed without an item");

    // Refused operations return no field
    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_result.status != mbr_pkg::ST_OK) |-> (m_result.extracted == '0))
        else $error("refused operation returned data");

    // Reported fill matches the state left behind by the executed item
    a_avail_match: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_result.bits_available == mbr_pkg::AVAIL_W'(held)))
        else $error("reported fill differs from buffer state");

endmodule

>>> rtl/mbr_in_stage.sv
// Input register of the bit reader: captures one item and holds it until it executes.
module mbr_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mbr_pkg::item_t  s_item,
    input  logic            advance,
    output logic            item_valid,
    output mbr_pkg::item_t  item
);

    logic           valid_reg;
    logic           valid_next;
    mbr_pkg::item_t item_reg;

    // Accept when empty or when the held item leaves this cycle
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/mbr_exec.sv
// Bit buffer state and the single-pass datapath for load, get, skip and put-back.
module mbr_exec (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mbr_pkg::item_t             item,
    input  logic                       advance,
    output mbr_pkg::result_t           result,
    output logic [mbr_pkg::HELD_W-1:0] held
);

    // Buffer is MSB aligned: bit BUF_BITS-1 is the next bit out, unused bits are zero
    logic [mbr_pkg::BUF_BITS-1:0] buf_reg;
    logic [mbr_pkg::BUF_BITS-1:0] buf_next;
    logic [mbr_pkg::HELD_W-1:0]   held_reg;
    logic [mbr_pkg::HELD_W-1:0]   held_next;

    logic [mbr_pkg::SUM_W-1:0]    held_w;
    logic [mbr_pkg::SUM_W-1:0]    count_w;
    logic [mbr_pkg::SUM_W-1:0]    put_sum;
    logic [mbr_pkg::SUM_W-1:0]    back_shift;
    logic [mbr_pkg::BUF_BITS-1:0] load_word;
    logic [mbr_pkg::BUF_BITS-1:0] front_word;
    logic [mbr_pkg::BUF_BITS-1:0] put_word;
    logic [mbr_pkg::VALUE_W-1:0]  value;
    mbr_pkg::status_t             status;

    assign held_w     = mbr_pkg::SUM_W'(held_reg);
    assign count_w    = mbr_pkg::SUM_W'(item.bit_count);
    assign put_sum    = held_w + count_w;
    assign back_shift = mbr_pkg::SUM_W'(mbr_pkg::BUF_BITS) - count_w;

    // Shifters: byte placed behind the held bits, front field and put-back word
    assign load_word  = {item.byte_value, {(mbr_pkg::BUF_BITS - mbr_pkg::BYTE_W){1'b0}}}
                        >> held_reg;
    assign front_word = buf_reg >> back_shift;
    assign put_word   = {{(mbr_pkg::BUF_BITS - mbr_pkg::VALUE_W){1'b0}}, item.put_value}
                        << back_shift;

    // Decode the operation and choose the next state
    always_comb begin
        buf_next  = buf_reg;
        held_next = held_reg;
        value     = '0;
        status    = mbr_pkg::ST_OK;
        case (item.opcode)
            mbr_pkg::OP_LOAD: begin
                if (held_w > mbr_pkg::SUM_W'(mbr_pkg::BUF_BITS - mbr_pkg::BYTE_BITS)) begin
                    status = mbr_pkg::ST_OVERFLOW;
                end else begin
                    buf_next  = buf_reg | load_word;
                    held_next = held_reg + mbr_pkg::HELD_W'(mbr_pkg::BYTE_BITS);
                end
            end
            mbr_pkg::OP_GET: begin
                if (count_w > mbr_pkg::SUM_W'(mbr_pkg::FIELD_BITS)) begin
                    status = mbr_pkg::ST_COUNT;
                end else if (count_w > held_w) begin
                    status = mbr_pkg::ST_UNDERRUN;
                end else begin
                    value     = front_word[mbr_pkg::VALUE_W-1:0];
                    buf_next  = buf_reg << item.bit_count;
                    held_next = held_reg - mbr_pkg::HELD_W'(item.bit_count);
                end
            end
            mbr_pkg::OP_SKIP: begin
                if (count_w > held_w) begin
                    status = mbr_pkg::ST_UNDERRUN;
                end else begin
                    buf_next  = buf_reg << item.bit_count;
                    held_next = held_reg - mbr_pkg::HELD_W'(item.bit_count);
                end
            end
            mbr_pkg::OP_PUT: begin
                if (count_w > mbr_pkg::SUM_W'(mbr_pkg::FIELD_BITS)) begin
                    status = mbr_pkg::ST_COUNT;
                end else if (put_sum > mbr_pkg::SUM_W'(mbr_pkg::BUF_BITS)) begin
                    status = mbr_pkg::ST_OVERFLOW;
                end else begin
                    buf_next  = (buf_reg >> item.bit_count) | put_word;
                    held_next = put_sum[mbr_pkg::HELD_W-1:0];
                end
            end
            default: begin
                status = mbr_pkg::ST_OK;
            end
        endcase
    end

    // Commit state only when the item moves into the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg  <= '0;
            held_reg <= '0;
        end else if (advance) begin
            buf_reg  <= buf_next;
            held_reg <= held_next;
        end
    end

    assign result.extracted      = value;
    assign result.bits_available = mbr_pkg::AVAIL_W'(held_next);
    assign result.status         = status;
    assign held                  = held_reg;

endmodule

>>> rtl/mbr_out_stage.sv
// Result register of the bit reader: holds one result until the downstream side takes it.
module mbr_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  mbr_pkg::result_t  result,
    output logic              advance,
    output logic              m_valid,
    input  logic              m_ready,
    output mbr_pkg::result_t  m_result
);

    logic             valid_reg;
    logic             valid_next;
    mbr_pkg::result_t result_reg;

    // Advance when the register is empty or its result is taken now
    assign advance    = item_valid && (!valid_reg || m_ready);
    assign valid_next = advance || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule
